@@ rtl/core/lffp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lffp_pkg;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned RES_CAP = 16;
  localparam int unsigned DIV_STEPS = 36;
  localparam int unsigned SQRT_STEPS = 27;

  localparam logic [1:0] REG_FADE_EN = 2'd0;
  localparam logic [1:0] REG_FADE_DUR = 2'd1;
  localparam logic [1:0] REG_COMP_CNT = 2'd2;

  typedef struct packed {
    logic               is_frame;
    logic               load_ok;
    logic [3:0]         slot;
    logic signed [20:0] place;
    logic [19:0]        size;
    logic signed [24:0] lx;
    logic signed [24:0] ly;
    logic               z_neg;
    logic               on_screen;
    logic               occluded;
    logic [19:0]        elapsed;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FADE,
    ST_SQ1,
    ST_SQ2,
    ST_SQC,
    ST_SQRT,
    ST_SQA,
    ST_FIN,
    ST_EMPTY,
    ST_RD,
    ST_MUL,
    ST_OUT
  } state_t;

  function automatic logic [16:0] clamp_unit(input logic signed [37:0] v);
    logic [16:0] r;
    if (v < 38'sd0) r = 17'd0;
    else if (v > 38'sd65536) r = 17'd65536;
    else r = v[16:0];
    return r;
  endfunction

  function automatic logic [24:0] sat_xy(input logic signed [33:0] v);
    logic [24:0] r;
    if (v > 34'sd16777215) r = 25'h0FF_FFFF;
    else if (v < -34'sd16777216) r = 25'h100_0000;
    else r = v[24:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lffp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lffp_front import lffp_pkg::*; #(
  parameter int MAX_COMPONENTS = 16
) (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic [3:0]         slot,
  input  wire logic signed [20:0] comp_position,
  input  wire logic [19:0]        comp_size,
  input  wire logic signed [24:0] lens_x,
  input  wire logic signed [24:0] lens_y,
  input  wire logic signed [24:0] lens_z,
  input  wire logic [16:0]        depth_sample,
  input  wire logic [19:0]        elapsed,
  input  wire logic               q_full,
  output logic                    q_push,
  output item_t                   q_item
);

  always_comb begin
    in_stall = q_full;
    q_push = in_valid && !q_full;
    q_item.is_frame = mode;
    q_item.load_ok = (32'(slot) < MAX_COMPONENTS);
    q_item.slot = slot;
    q_item.place = comp_position;
    q_item.size = comp_size;
    q_item.lx = lens_x;
    q_item.ly = lens_y;
    q_item.z_neg = lens_z[24];
    q_item.on_screen = (lens_x >= 25'sd0) && (lens_x <= 25'sd65536) &&
                       (lens_y >= 25'sd0) && (lens_y <= 25'sd65536);
    // depth is unsigned, compare with one spare sign bit
    q_item.occluded = (26'(lens_z) >= $signed({9'b0, depth_sample}));
    q_item.elapsed = elapsed;
  end

endmodule
`default_nettype wire

@@ rtl/core/lffp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lffp_queue import lffp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      head
);

  item_t       entries [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full = (count == 2'(QUEUE_DEPTH));
  assign empty = (count == 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lffp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lffp_back import lffp_pkg::*; #(
  parameter int MAX_COMPONENTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fade_en,
  input  wire logic [19:0] fade_dur,
  input  wire logic [4:0]  comp_count,
  input  wire logic        q_empty,
  input  wire item_t       head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       index,
  output logic [24:0]      quad_x,
  output logic [24:0]      quad_y,
  output logic [19:0]      quad_size,
  output logic [16:0]      alpha,
  output logic             draw,
  output logic             last
);

  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CAP = (MAX_COMPONENTS < RES_CAP) ? MAX_COMPONENTS : RES_CAP;

  state_t state, state_next;

  logic signed [20:0] place_mem [MAX_COMPONENTS];
  logic [19:0]        size_mem [MAX_COMPONENTS];
  logic signed [20:0] rd_place;
  logic [19:0]        rd_size;

  logic [16:0] intensity;
  logic [16:0] last_inside;
  logic        started;
  logic        f_first;
  logic        f_occl;
  logic        f_zneg;
  logic signed [24:0] f_lx;
  logic signed [24:0] f_ly;
  logic signed [26:0] tx;
  logic signed [26:0] ty;
  logic signed [37:0] ival;
  logic [5:0]  cnt;

  logic [35:0] dq;
  logic [19:0] rem;
  logic [20:0] rem_sh;

  logic signed [51:0] dx2;
  logic signed [51:0] dy2;
  logic signed [25:0] dx;
  logic signed [25:0] dy;
  logic [53:0] sq;
  logic [53:0] sq_n;
  logic [26:0] root;
  logic [29:0] srem;
  logic [31:0] srem_sh;
  logic [31:0] trial;

  logic [16:0] mult;
  logic [4:0]  nq;
  logic [4:0]  k;
  logic signed [47:0] prod_x;
  logic signed [47:0] prod_y;
  logic [36:0] prod_s;
  logic signed [33:0] sum_x;
  logic signed [33:0] sum_y;
  logic [4:0]  n_eff;
  logic signed [37:0] fade_val;

  logic out_free;
  logic out_load;
  logic out_blank;

  assign out_free = !out_valid || !out_stall;
  assign rem_sh = {rem, dq[35]};
  assign dx = 26'(f_lx) - 26'sd32768;
  assign dy = 26'(f_ly) - 26'sd32768;
  assign sq = {1'b0, (52'(dx2) + 52'(dy2)), 1'b0};
  assign srem_sh = {srem, sq_n[53:52]};
  assign trial = {3'b0, root, 2'b01};
  assign sum_x = 34'(f_lx) + 34'(prod_x >>> 16);
  assign sum_y = 34'(f_ly) + 34'(prod_y >>> 16);
  assign n_eff = (comp_count > 5'(CAP)) ? 5'(CAP) : comp_count;
  assign fade_val = f_occl ? (f_first ? 38'sd0 : ival - $signed({2'b0, dq}))
                           : (f_first ? 38'sd65536 : ival + $signed({2'b0, dq}));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    out_load = 1'b0;
    out_blank = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (head.is_frame) begin
            if (!fade_en) state_next = ST_FIN;
            else if (!head.on_screen) state_next = ST_SQ1;
            else if (fade_dur != 20'd0) state_next = ST_DIV;
            else state_next = ST_FIN;
          end
        end
      end
      ST_DIV:  if (cnt == 6'(DIV_STEPS - 1)) state_next = ST_FADE;
      ST_FADE: state_next = ST_FIN;
      ST_SQ1:  state_next = ST_SQ2;
      ST_SQ2:  state_next = ST_SQC;
      ST_SQC:  state_next = (sq > 54'h1_0000_0000) ? ST_SQRT : ST_FIN;
      ST_SQRT: if (cnt == 6'(SQRT_STEPS - 1)) state_next = ST_SQA;
      ST_SQA:  state_next = ST_FIN;
      ST_FIN: begin
        if (f_zneg || n_eff == 5'd0) state_next = ST_EMPTY;
        else state_next = ST_RD;
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          out_blank = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD:  state_next = ST_MUL;
      ST_MUL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = (k + 5'd1 == nq) ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // component table
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_pop && !head.is_frame && head.load_ok) begin
      place_mem[AW'(head.slot)] <= head.place;
      size_mem[AW'(head.slot)] <= head.size;
    end
    rd_place <= place_mem[AW'(k)];
    rd_size <= size_mem[AW'(k)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity <= 17'(ONE_Q16);
      last_inside <= 17'(ONE_Q16);
      started <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop && head.is_frame) begin
            started <= 1'b1;
            if (fade_en && head.on_screen && fade_dur == 20'd0) last_inside <= intensity;
          end
        end
        ST_FADE: last_inside <= clamp_unit(fade_val);
        ST_FIN:  intensity <= f_zneg ? 17'd0 : clamp_unit(ival);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        f_first <= !started;
        f_occl <= head.occluded;
        f_zneg <= head.z_neg;
        f_lx <= head.lx;
        f_ly <= head.ly;
        tx <= (27'sd32768 - 27'(head.lx)) <<< 1;
        ty <= (27'sd32768 - 27'(head.ly)) <<< 1;
        ival <= 38'(intensity);
        dq <= {head.elapsed, 16'b0};
        rem <= 20'd0;
        cnt <= 6'd0;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, fade_dur}) begin
          rem <= 20'(rem_sh - {1'b0, fade_dur});
          dq <= {dq[34:0], 1'b1};
        end else begin
          rem <= rem_sh[19:0];
          dq <= {dq[34:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
      end
      ST_FADE: ival <= fade_val;
      ST_SQ1:  dx2 <= dx * dx;
      ST_SQ2:  dy2 <= dy * dy;
      ST_SQC: begin
        sq_n <= sq;
        root <= 27'd0;
        srem <= 30'd0;
        cnt <= 6'd0;
        ival <= 38'(last_inside);
      end
      ST_SQRT: begin
        if (srem_sh >= trial) begin
          srem <= 30'(srem_sh - trial);
          root <= {root[25:0], 1'b1};
        end else begin
          srem <= srem_sh[29:0];
          root <= {root[25:0], 1'b0};
        end
        sq_n <= {sq_n[51:0], 2'b00};
        cnt <= cnt + 6'd1;
      end
      ST_SQA: ival <= 38'(last_inside) - 38'(root) + 38'sd65536;
      ST_FIN: begin
        mult <= 17'd49152 + 17'(clamp_unit(ival) >> 2);
        nq <= n_eff;
        k <= 5'd0;
      end
      ST_MUL: begin
        prod_x <= tx * rd_place;
        prod_y <= ty * rd_place;
        prod_s <= rd_size * mult;
      end
      ST_OUT: if (out_free) k <= k + 5'd1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (out_blank) begin
        index <= 4'd0;
        quad_x <= 25'd0;
        quad_y <= 25'd0;
        quad_size <= 20'd0;
        alpha <= 17'd0;
        draw <= 1'b0;
        last <= 1'b1;
      end else begin
        index <= k[3:0];
        quad_x <= sat_xy(sum_x);
        quad_y <= sat_xy(sum_y);
        quad_size <= prod_s[35:16];
        alpha <= intensity;
        draw <= 1'b1;
        last <= (k + 5'd1 == nq);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lens_flare_fade_and_place_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lens flare fade and place core
// input channel (in_valid / in_stall): mode 0 loads one component entry
// (slot, comp_position, comp_size), mode 1 processes a frame (lens_x,
// lens_y, lens_z, depth_sample, elapsed)
// output channel (out_valid / out_stall): one quad per component in use,
// or a single draw=0 result when lens_z is negative or no component is set
// config via apb: 0 depth_fade_enable, 4 fade_duration, 8 component_count
// a two entry queue sits between the input stage and the frame engine, so
// items are taken while the engine works or the output stalls, until full
// frame: fading on screen with a nonzero duration runs a restoring divider,
// off screen it squares dx and dy and, if the scaled distance exceeds one,
// takes a square root; then each quad comes from the component table
// memory in steps (read, multiply, place)
// reset: intensity one, no frame seen, table contents undefined until loaded
// a stalled output holds its result and the engine waits on it
module lens_flare_fade_and_place_core import lffp_pkg::*; #(
  parameter int MAX_COMPONENTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic [3:0]         slot,
  input  wire logic signed [20:0] comp_position,
  input  wire logic [19:0]        comp_size,
  input  wire logic signed [24:0] lens_x,
  input  wire logic signed [24:0] lens_y,
  input  wire logic signed [24:0] lens_z,
  input  wire logic [16:0]        depth_sample,
  input  wire logic [19:0]        elapsed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              index,
  output logic [24:0]             quad_x,
  output logic [24:0]             quad_y,
  output logic [19:0]             quad_size,
  output logic [16:0]             alpha,
  output logic                    draw,
  output logic                    last
);

  logic        fade_en;
  logic [19:0] fade_dur;
  logic [4:0]  comp_count;

  logic  q_full, q_push, q_pop, q_empty;
  item_t q_item, q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_en <= 1'b1;
      fade_dur <= 20'd6554;
      comp_count <= 5'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FADE_EN:  fade_en <= pwdata[0];
        REG_FADE_DUR: fade_dur <= pwdata[19:0];
        REG_COMP_CNT: comp_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FADE_EN:  prdata = {31'b0, fade_en};
      REG_FADE_DUR: prdata = {12'b0, fade_dur};
      REG_COMP_CNT: prdata = {27'b0, comp_count};
      default:      prdata = 32'd0;
    endcase
  end

  lffp_front #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .slot(slot),
    .comp_position(comp_position), .comp_size(comp_size),
    .lens_x(lens_x), .lens_y(lens_y), .lens_z(lens_z),
    .depth_sample(depth_sample), .elapsed(elapsed),
    .q_full(q_full), .q_push(q_push), .q_item(q_item)
  );

  lffp_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  lffp_back #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
    .clk(clk), .rst(rst), .fade_en(fade_en), .fade_dur(fade_dur),
    .comp_count(comp_count), .q_empty(q_empty), .head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .index(index),
    .quad_x(quad_x), .quad_y(quad_y), .quad_size(quad_size), .alpha(alpha),
    .draw(draw), .last(last)
  );

endmodule
`default_nettype wire

@@ bench/lens_flare_fade_and_place_core_tb.sv @@
`timescale 1ns / 1ps
module lens_flare_fade_and_place_core_tb;
  import lffp_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    bit                 mode;
    bit [3:0]           slot;
    logic signed [20:0] pos;
    bit [19:0]          size;
    logic signed [24:0] lx;
    logic signed [24:0] ly;
    logic signed [24:0] lz;
    bit [16:0]          depth;
    bit [19:0]          el;
    bit                 blank; // typed expectation: one empty result
  } flare_item_t;

  typedef struct {
    bit [3:0]  index;
    bit [24:0] qx;
    bit [24:0] qy;
    bit [19:0] size;
    bit [16:0] alpha;
    bit        draw;
    bit        last;
  } quad_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic mode = 0;
  logic [3:0] slot = '0;
  logic signed [20:0] comp_position = '0;
  logic [19:0] comp_size = '0;
  logic signed [24:0] lens_x = '0, lens_y = '0, lens_z = '0;
  logic [16:0] depth_sample = '0;
  logic [19:0] elapsed = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [3:0] index;
  logic [24:0] quad_x, quad_y;
  logic [19:0] quad_size;
  logic [16:0] alpha;
  logic draw, last;

  lens_flare_fade_and_place_core dut (.*);

  always #2 clk = ~clk;

  // predictor state
  int fade_level = ONE_Q16;
  int inside_level = ONE_Q16;
  bit frame_seen = 0;
  bit cfg_fade_en = 1;
  int unsigned cfg_duration = 6554;
  int unsigned cfg_count = 0;
  logic signed [20:0] place_tab [16];
  bit [19:0] size_tab [16];

  quad_t expected_quads[$];
  flare_item_t directed[$];
  int fails = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  function automatic void queue_quad(input quad_t q);
    expected_quads.insert(expected_quads.size(), q);
  endfunction

  function automatic void queue_row(input flare_item_t it);
    directed.insert(directed.size(), it);
  endfunction

  function automatic longint isqrt(input longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 27;
    while (lo < hi) begin
      mid = (lo + hi + 1) >>> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void push_blank();
    quad_t q;
    q = '{default: 0};
    q.last = 1;
    queue_quad(q);
  endfunction

  function automatic void predict_quads(input flare_item_t it);
    longint lx, ly, lz, lvl, dx, dy, sq, tx, ty, p, qx, qy;
    longint unsigned mult, sz;
    bit first, on;
    int n;
    quad_t q;
    if (!it.mode) begin
      place_tab[it.slot] = it.pos;
      size_tab[it.slot] = it.size;
      return;
    end
    lx = it.lx;
    ly = it.ly;
    lz = it.lz;
    first = !frame_seen;
    frame_seen = 1;
    lvl = fade_level;
    if (cfg_fade_en) begin
      on = lx >= 0 && lx <= ONE_Q16 && ly >= 0 && ly <= ONE_Q16;
      if (on) begin
        if (cfg_duration != 0) begin
          if (lz >= longint'(it.depth))
            lvl = first ? 0 : lvl - ((longint'(it.el) << 16) / cfg_duration);
          else
            lvl = first ? ONE_Q16 : lvl + ((longint'(it.el) << 16) / cfg_duration);
        end
        inside_level = int'(clip(lvl, 0, ONE_Q16));
      end else begin
        dx = lx - 32768;
        dy = ly - 32768;
        sq = 2 * (dx * dx + dy * dy);
        if (sq > (64'd1 << 32)) lvl = inside_level - (isqrt(sq) - ONE_Q16);
        else lvl = inside_level;
      end
    end
    lvl = clip(lvl, 0, ONE_Q16);
    if (lz < 0) begin
      fade_level = 0;
      push_blank();
      return;
    end
    fade_level = int'(lvl);
    n = cfg_count > 16 ? 16 : cfg_count;
    if (n == 0) begin
      push_blank();
      return;
    end
    mult = 49152 + (lvl >> 2);
    tx = 2 * (32768 - lx);
    ty = 2 * (32768 - ly);
    for (int k = 0; k < n; k++) begin
      p = place_tab[k];
      sz = (longint'(size_tab[k]) * mult) >> 16;
      qx = clip(lx + ((tx * p) >>> 16), -16777216, 16777215);
      qy = clip(ly + ((ty * p) >>> 16), -16777216, 16777215);
      q.index = 4'(k);
      q.qx = qx[24:0];
      q.qy = qy[24:0];
      q.size = sz[19:0];
      q.alpha = lvl[16:0];
      q.draw = 1;
      q.last = (k == n - 1);
      queue_quad(q);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    quad_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quads.size() == 0) begin
        $error("unexpected result transfer, index %0d", index);
        fails++;
      end else begin
        e = expected_quads.pop_front();
        if (index !== e.index) begin
          $error("index: expected %0d got %0d", e.index, index); fails++;
        end
        if (quad_x !== e.qx) begin
          $error("quad_x: expected %h got %h", e.qx, quad_x); fails++;
        end
        if (quad_y !== e.qy) begin
          $error("quad_y: expected %h got %h", e.qy, quad_y); fails++;
        end
        if (quad_size !== e.size) begin
          $error("quad_size: expected %h got %h", e.size, quad_size); fails++;
        end
        if (alpha !== e.alpha) begin
          $error("alpha: expected %0d got %0d", e.alpha, alpha); fails++;
        end
        if (draw !== e.draw) begin
          $error("draw: expected %0d got %0d", e.draw, draw); fails++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d got %0d", e.last, last); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(input flare_item_t it);
    in_valid <= 1;
    mode <= it.mode;
    slot <= it.slot;
    comp_position <= it.pos;
    comp_size <= it.size;
    lens_x <= it.lx;
    lens_y <= it.ly;
    lens_z <= it.lz;
    depth_sample <= it.depth;
    elapsed <= it.el;
    do @(posedge clk); while (in_stall);
    predict_quads(it);
    if (it.blank) begin
      void'(expected_quads.pop_back());
      push_blank();
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] reg_id, input int unsigned value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (reg_id)
      REG_FADE_EN: cfg_fade_en = value[0];
      REG_FADE_DUR: cfg_duration = value & 32'hFFFFF;
      REG_COMP_CNT: cfg_count = value & 32'h1F;
      default: ;
    endcase
  endtask

  task automatic configure(input bit en, input int unsigned dur, input int unsigned cnt);
    drain();
    write_reg(REG_FADE_EN, en);
    write_reg(REG_FADE_DUR, dur);
    write_reg(REG_COMP_CNT, cnt);
  endtask

  function automatic flare_item_t load_row(input int s, input int p, input int unsigned sz);
    flare_item_t it;
    it = '{default: 0};
    it.slot = 4'(s);
    it.pos = 21'(p);
    it.size = 20'(sz);
    return it;
  endfunction

  function automatic flare_item_t frame_row(input int x, input int y, input int z,
                                            input int d, input int unsigned e,
                                            input bit blank);
    flare_item_t it;
    it = '{default: 0};
    it.mode = 1;
    it.lx = 25'(x);
    it.ly = 25'(y);
    it.lz = 25'(z);
    it.depth = 17'(d);
    it.el = 20'(e);
    it.blank = blank;
    return it;
  endfunction

  function automatic flare_item_t random_row();
    flare_item_t it;
    int pick;
    it.mode = ($urandom_range(99) >= 15);
    it.slot = 4'($urandom());
    it.pos = 21'($urandom());
    it.size = 20'($urandom());
    it.blank = 0;
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.lx = 25'($urandom_range(65536));
      it.ly = 25'($urandom_range(65536));
    end else if (pick < 75) begin
      it.lx = 25'(int'($urandom_range(500000)) - 200000);
      it.ly = 25'(int'($urandom_range(500000)) - 200000);
    end else begin
      it.lx = 25'($urandom());
      it.ly = 25'($urandom());
    end
    pick = $urandom_range(99);
    if (pick < 70) it.lz = 25'($urandom_range(65536));
    else if (pick < 85) it.lz = 25'(-int'($urandom_range(1, 70000)));
    else it.lz = 25'($urandom());
    it.depth = ($urandom_range(9) == 0) ? 17'd65536 : 17'($urandom_range(65535));
    it.el = ($urandom_range(3) == 0) ? 20'($urandom()) : 20'($urandom_range(3000));
    return it;
  endfunction

  initial begin
    int idle_set [4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{22, 22}};
    repeat (2) @(posedge clk);
    rst <= 0;

    // no components yet: only empty results
    queue_row(frame_row(30000, 30000, -1, 40000, 100, 1));
    queue_row(frame_row(65536, 0, 16777215, 65536, 1048575, 1));
    queue_row(frame_row(-16777216, 16777215, 0, 0, 0, 1));
    for (int s = 0; s < 16; s++) begin
      case (s)
        0: queue_row(load_row(s, -1048576, 1048575));
        1: queue_row(load_row(s, 1048575, 0));
        2: queue_row(load_row(s, 0, 65536));
        3: queue_row(load_row(s, 65536, 32768));
        default: queue_row(load_row(s, int'($urandom_range(2097151)) - 1048576,
                                    $urandom()));
      endcase
    end
    foreach (directed[i]) send(directed[i]);
    configure(1, 6554, 16);
    directed.delete();
    queue_row(frame_row(32768, 32768, 100, 40000, 1000, 0));
    queue_row(frame_row(32768, 32768, 50000, 40000, 1048575, 0));
    queue_row(frame_row(0, 65536, 0, 0, 3277, 0));
    queue_row(frame_row(16777215, 16777215, 10, 65536, 0, 0));
    queue_row(frame_row(-16777216, -16777216, 10, 65536, 0, 0));
    queue_row(frame_row(70000, 32768, 10, 65536, 0, 0));
    queue_row(frame_row(32768, 32768, -16777216, 65536, 500, 1));
    foreach (directed[i]) send(directed[i]);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(1, 6554, 16);
        1: configure(1, 0, 5);
        2: configure(0, 1048575, 1);
        3: configure(1, 1, 31);
        4: configure(1, 1048575, 0);
        5: configure(1, $urandom_range(1, 40000), $urandom_range(1, 16));
        6: configure(1'($urandom_range(1)), $urandom(), $urandom_range(31));
        default: configure(1, 6554, 16);
      endcase
      send_idle_pct = idle_set[ph % 4][0];
      stall_pct = idle_set[ph % 4][1];
      for (int i = 0; i < 40; i++) send(random_row());
    end

    in_valid <= 0;
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
